[design/assert_macros.svh]
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[design/plvs_pkg.sv]
// Types and constants of the point light vertex shader.
`timescale 1ns / 1ps
package plvs_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 25;
  localparam int unsigned SqW    = 52;
  localparam int unsigned DistW  = 26;
  localparam int unsigned WgtW   = 17;
  localparam int unsigned AccW   = 32;
  localparam int unsigned LightW = 3 * CoordW + 2 * RadW + 24;
  localparam logic KindLoad  = 1'b0;
  localparam logic KindShade = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LATCH, ST_SQ, ST_SUM, ST_ROOT, ST_CMP, ST_DIV, ST_ACC,
    ST_SCALE, ST_OUT
  } plvs_state_t;

  typedef struct packed {
    logic load_vertex;
    logic load_light;
    logic start_sq;
    logic root_init;
    logic root_step;
    logic cmp;
    logic div_init;
    logic div_step;
    logic acc;
    logic scale;
  } plvs_cmd_t;

  typedef struct packed {
    logic root_done;
    logic div_done;
    logic skip;
    logic full;
  } plvs_stat_t;
endpackage

[design/plvs_ram.sv]
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module plvs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[design/plvs_datapath.sv]
// Datapath: light distance, falloff weight and colour accumulation.
`timescale 1ns / 1ps
module plvs_datapath import plvs_pkg::*; (
  input  logic                clk,
  input  plvs_cmd_t           cmd,
  output plvs_stat_t          stat,
  input  logic [CoordW-1:0]   vx_in,
  input  logic [CoordW-1:0]   vy_in,
  input  logic [CoordW-1:0]   vz_in,
  input  logic [23:0]         base_in,
  input  logic [LightW-1:0]   light,
  output logic [23:0]         lit
);
  localparam int unsigned MulW = 2 * CoordW + 2;
  logic signed [CoordW-1:0] vx, vy, vz;
  logic [23:0] base;
  logic signed [CoordW:0] dx, dy, dz;
  logic signed [MulW-1:0] ex, ey, ez;
  logic [SqW-1:0] sqx, sqy, sqz;
  logic [RadW-1:0] inner, outer;
  logic [23:0] col;
  logic [SqW-1:0] rem_v;
  logic [DistW-1:0] root;
  logic [4:0] rcnt;
  logic [DistW+16:0] drem;
  logic [WgtW-1:0] w;
  logic [4:0] dcnt;
  logic [AccW-1:0] acc_r, acc_g, acc_b;
  logic [DistW-1:0] gap;
  logic [RadW:0] den;
  logic [SqW-1:0] trial;
  logic [DistW+16:0] dtrial;
  logic [24:0] mr, mg, mb;
  logic [AccW+7:0] pr, pg, pb;

  assign ex = MulW'(dx);
  assign ey = MulW'(dy);
  assign ez = MulW'(dz);
  assign trial  = SqW'({root, 2'b01}) << (2 * rcnt);
  assign gap    = {1'b0, outer} - root;
  assign dtrial = {17'd0, den} << (dcnt - 5'd1);
  assign mr = {17'd0, col[23:16]} * {8'd0, w};
  assign mg = {17'd0, col[15:8]} * {8'd0, w};
  assign mb = {17'd0, col[7:0]} * {8'd0, w};
  assign pr = {{AccW{1'b0}}, base[23:16]} * {8'd0, acc_r};
  assign pg = {{AccW{1'b0}}, base[15:8]} * {8'd0, acc_g};
  assign pb = {{AccW{1'b0}}, base[7:0]} * {8'd0, acc_b};
  assign stat.root_done = (rcnt == 5'd0);
  assign stat.div_done  = (dcnt == 5'd0);
  assign stat.skip  = ({1'b0, outer} <= root);
  assign stat.full  = (root <= {1'b0, inner});

  always_ff @(posedge clk) begin
    if (cmd.load_vertex) begin
      vx <= vx_in; vy <= vy_in; vz <= vz_in; base <= base_in;
      acc_r <= '0; acc_g <= '0; acc_b <= '0;
    end
    if (cmd.load_light) begin
      dx <= $signed({light[LightW-1], light[LightW-1 -: CoordW]}) - $signed({vx[CoordW-1], vx});
      dy <= $signed({light[LightW-1-CoordW], light[LightW-1-CoordW -: CoordW]})
            - $signed({vy[CoordW-1], vy});
      dz <= $signed({light[LightW-1-2*CoordW], light[LightW-1-2*CoordW -: CoordW]})
            - $signed({vz[CoordW-1], vz});
      inner <= light[2*RadW+23 -: RadW];
      outer <= light[RadW+23 -: RadW];
      col   <= light[23:0];
    end
    if (cmd.start_sq) begin
      sqx <= SqW'(ex * ex); sqy <= SqW'(ey * ey); sqz <= SqW'(ez * ez);
    end
    if (cmd.root_init) begin
      rem_v <= sqx + sqy + sqz; root <= '0; rcnt <= 5'd25;
    end else if (cmd.root_step) begin
      // One result bit a cycle, restoring method.
      if ((rem_v >> (2 * rcnt)) >= SqW'({root, 2'b01})) begin
        rem_v <= rem_v - trial;
        root <= {root[DistW-2:0], 1'b1};
      end else begin
        root <= {root[DistW-2:0], 1'b0};
      end
      if (rcnt != 5'd0) rcnt <= rcnt - 5'd1;
    end
    if (cmd.cmp) den <= {1'b0, outer} - {1'b0, inner};
    if (cmd.div_init) begin
      drem <= {1'b0, gap, 16'd0};
      if (stat.full) begin
        w <= WgtW'(65536); dcnt <= 5'd0;
      end else begin
        w <= '0; dcnt <= 5'd16;
      end
    end else if (cmd.div_step) begin
      if (drem >= dtrial) begin
        drem <= drem - dtrial; w <= w | (WgtW'(1) << (dcnt - 5'd1));
      end
      if (dcnt != 5'd0) dcnt <= dcnt - 5'd1;
    end
    if (cmd.acc) begin
      acc_r <= acc_r + AccW'(mr);
      acc_g <= acc_g + AccW'(mg);
      acc_b <= acc_b + AccW'(mb);
    end
    if (cmd.scale) lit <= {pr[31:24], pg[31:24], pb[31:24]};
  end
endmodule

[design/plvs_ctrl.sv]
// Controller: walks the light slots for each vertex item.
`timescale 1ns / 1ps
module plvs_ctrl import plvs_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     out_taken,
  input  logic                     slot_en,
  input  plvs_stat_t               stat,
  output plvs_cmd_t                cmd,
  output logic [$clog2(SLOTS+1)-1:0] slot,
  output logic                     busy,
  output logic                     out_valid
);
  localparam int unsigned SW = $clog2(SLOTS + 1);
  plvs_state_t state, state_next;
  logic [SW-1:0] slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; slot <= '0;
    end else begin
      state <= state_next; slot <= slot_next;
    end
  end

  always_comb begin
    state_next = state;
    slot_next  = slot;
    cmd = '0;
    busy = (state != ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_vertex = 1'b1; slot_next = '0; state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (slot == SW'(SLOTS)) state_next = ST_SCALE;
        else state_next = ST_LATCH;
      end
      ST_LATCH: begin
        if (slot_en) begin cmd.load_light = 1'b1; state_next = ST_SQ; end
        else begin slot_next = slot + SW'(1); state_next = ST_READ; end
      end
      ST_SQ:   begin cmd.start_sq = 1'b1; state_next = ST_SUM; end
      // Sum the squares straight into the root unit.
      ST_SUM:  begin cmd.root_init = 1'b1; state_next = ST_ROOT; end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_done) state_next = ST_CMP;
      end
      ST_CMP: begin
        if (stat.skip) begin slot_next = slot + SW'(1); state_next = ST_READ; end
        else begin cmd.cmp = 1'b1; cmd.div_init = 1'b1; state_next = ST_DIV; end
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_ACC;
        else cmd.div_step = 1'b1;
      end
      ST_ACC: begin cmd.acc = 1'b1; slot_next = slot + SW'(1); state_next = ST_READ; end
      ST_SCALE: begin cmd.scale = 1'b1; state_next = ST_OUT; end
      ST_OUT: begin
        if (out_taken) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[design/point_light_vertex_shader_unit.sv]
// Top level of the point light vertex shader.
// From vertex accept to m_tvalid the controller reads every slot in turn; each enabled light
// runs the 26-step root, and a light in the falloff band also the 16-step divide.
// One vertex item is shaded at a time, the next accepted in the cycle after the result
// leaves; load items are taken while idle. Reset (rst, synchronous) clears the enable bits
// and the controller; light data stays undefined until a slot is written.
`timescale 1ns / 1ps
module point_light_vertex_shader_unit import plvs_pkg::*; #(
  parameter int unsigned LIGHT_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kind
  input  logic        s_tuser,
  // slot[3:0], enable[4], coord_x[28:5], coord_y[52:29], coord_z[76:53],
  // inner_radius[101:77], outer_radius[126:102], red[134:127], green[142:135],
  // blue[150:143]
  input  logic [151:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // lit_red[7:0], lit_green[15:8], lit_blue[23:16]
  output logic [23:0] m_tdata
);
  localparam int unsigned AW = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
  plvs_cmd_t  cmd;
  plvs_stat_t stat;
  logic [$clog2(LIGHT_SLOTS+1)-1:0] slot;
  logic busy, accept, is_load, wr_ok;
  logic [LIGHT_SLOTS-1:0] en;
  logic [LightW-1:0] rdata;
  logic [23:0] lit;

  assign s_tready = !busy;
  assign accept = s_tvalid && s_tready;
  assign is_load = accept && (s_tuser == KindLoad);
  // Drop loads aimed past the last slot.
  assign wr_ok = is_load && ({28'd0, s_tdata[3:0]} < 32'(LIGHT_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) en <= '0;
    else if (wr_ok) en[AW'(s_tdata[3:0])] <= s_tdata[4];
  end

  plvs_ram #(.WIDTH(LightW), .DEPTH(LIGHT_SLOTS)) u_ram (
    .clk(clk), .we(wr_ok), .waddr(AW'(s_tdata[3:0])),
    .wdata({s_tdata[28:5], s_tdata[52:29], s_tdata[76:53], s_tdata[101:77],
            s_tdata[126:102], s_tdata[134:127], s_tdata[142:135], s_tdata[150:143]}),
    .raddr(AW'(slot)), .rdata(rdata)
  );

  plvs_ctrl #(.SLOTS(LIGHT_SLOTS)) u_ctrl (
    .clk(clk), .rst(rst), .start(accept && (s_tuser == KindShade)),
    .out_taken(m_tready), .slot_en(en[AW'(slot)]), .stat(stat), .cmd(cmd),
    .slot(slot), .busy(busy), .out_valid(m_tvalid)
  );

  plvs_datapath u_dp (
    .clk(clk), .cmd(cmd), .stat(stat), .vx_in(s_tdata[28:5]), .vy_in(s_tdata[52:29]),
    .vz_in(s_tdata[76:53]),
    .base_in({s_tdata[134:127], s_tdata[142:135], s_tdata[150:143]}),
    .light(rdata), .lit(lit)
  );

  assign m_tdata = {lit[7:0], lit[15:8], lit[23:16]};
endmodule

[design/plvs_checker.sv]
// Port checker for the point light vertex shader.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plvs_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready
);
  `CHK_IMPLY(a_no_in_while_out, clk, rst, m_tvalid, !s_tready, "input taken with result pending")
  `CHK_NEXT(a_out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped")
  `CHK_NEXT(a_out_once, clk, rst, m_tvalid && m_tready, !m_tvalid, "result repeated")
endmodule

bind point_light_vertex_shader_unit plvs_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready)
);

[verif/testbench.sv]
// Self-checking testbench for the point light vertex shader unit.
`timescale 1ns / 1ps
module testbench import plvs_pkg::*; ();

  localparam int NumSlots   = 16;
  localparam int RandItems  = 700;
  localparam int IdleLimit  = 200000;
  localparam int HoldCycles = 2000;
  localparam int TailCycles = 1000;
  localparam int MaxReports = 10;

  typedef struct {
    logic            kind;
    logic [3:0]      slot;
    logic            enable;
    logic [23:0]     x, y, z;
    logic [24:0]     inner, outer;
    logic [7:0]      r, g, b;
  } plvs_item_t;

  // Light table and shading prediction; expected colours kept in order.
  class shade_scoreboard;
    bit         lit_on [NumSlots];
    plvs_item_t lights [NumSlots];
    logic [23:0] pending_colours [$];
    int mismatches;
    int shaded;

    function void note_input(plvs_item_t it);
      longint vx, vy, vz, dx, dy, dz;
      longint unsigned sq, d, w, root, rem, bitv;
      longint unsigned acc [3];
      longint unsigned lc [3];
      logic [23:0] res;
      int i;
      int c;
      if (it.kind == KindLoad) begin
        lit_on[it.slot] = it.enable;
        lights[it.slot] = it;
        return;
      end
      vx = longint'($signed(it.x));
      vy = longint'($signed(it.y));
      vz = longint'($signed(it.z));
      acc = '{0, 0, 0};
      for (i = 0; i < NumSlots; i++) begin
        if (!lit_on[i]) continue;
        dx = longint'($signed(lights[i].x)) - vx;
        dy = longint'($signed(lights[i].y)) - vy;
        dz = longint'($signed(lights[i].z)) - vz;
        sq = dx * dx + dy * dy + dz * dz;
        // bitwise integer square root
        root = 0;
        rem = sq;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
          if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
          end else begin
            root >>= 1;
          end
          bitv >>= 2;
        end
        d = root;
        if (lights[i].outer <= d) continue;
        if (d <= lights[i].inner) w = 65536;
        else w = ((lights[i].outer - d) << 16) / (lights[i].outer - lights[i].inner);
        lc = '{lights[i].r, lights[i].g, lights[i].b};
        for (c = 0; c < 3; c++) acc[c] += lc[c] * w;
      end
      res[7:0]   = 8'((it.r * acc[0]) >> 24);
      res[15:8]  = 8'((it.g * acc[1]) >> 24);
      res[23:16] = 8'((it.b * acc[2]) >> 24);
      pending_colours.push_back(res);
    endfunction

    function void check_result(logic [23:0] got);
      logic [23:0] want;
      shaded++;
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("unexpected result %h", got);
        return;
      end
      want = pending_colours.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                   want[7:0], want[15:8], want[23:16], got[7:0], got[15:8], got[23:16]);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser, m_tvalid, m_tready;
  logic [151:0] s_tdata;
  logic [23:0] m_tdata;

  shade_scoreboard board;
  int idle_cycles;
  bit hold_off;
  int loads_sent, shades_sent;

  point_light_vertex_shader_unit dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [151:0] pack_item(plvs_item_t it);
    return {it.b, it.g, it.r, it.outer, it.inner, it.z, it.y, it.x, it.enable, it.slot};
  endfunction

  // Present one item, hold it until accepted, then score it.
  task automatic send_item(plvs_item_t it);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= pack_item(it);
    do @(posedge clk); while (!s_tready);
    board.note_input(it);
    if (it.kind == KindLoad) loads_sent++;
    else shades_sent++;
    @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coord(int spread);
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic plvs_item_t rand_light(logic [3:0] s, logic en);
    plvs_item_t it;
    it.kind = KindLoad;
    it.slot = s;
    it.enable = en;
    it.x = rand_coord(4096); it.y = rand_coord(4096); it.z = rand_coord(4096);
    it.inner = 25'($urandom_range(0, 3000));
    it.outer = 25'($urandom_range(0, 6000));
    if ($urandom_range(0, 7) == 0) begin
      it.inner = 25'($urandom);
      it.outer = 25'($urandom);
    end
    {it.r, it.g, it.b} = 24'($urandom);
    return it;
  endfunction

  function automatic plvs_item_t rand_vertex();
    plvs_item_t it;
    it = rand_light(4'($urandom), 1'($urandom));
    it.kind = KindShade;
    it.x = rand_coord(4096); it.y = rand_coord(4096); it.z = rand_coord(4096);
    return it;
  endfunction

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 8) == 0);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Stall watchdog.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    plvs_item_t it;
    int k;
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    hold_off = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table gives black.
    it = rand_vertex();
    send_item(it);
    // Fully lit light at the origin, extreme colours and overflow wrap.
    it = rand_light(4'd0, 1'b1);
    it.x = '0; it.y = '0; it.z = '0; it.inner = 25'h1FFFFFF; it.outer = 25'h1FFFFFF;
    {it.r, it.g, it.b} = 24'hFFFFFF;
    send_item(it);
    it = rand_light(4'd1, 1'b1);
    it.x = '0; it.y = '0; it.z = '0; it.inner = 25'h1FFFFFF; it.outer = 25'h1FFFFFF;
    {it.r, it.g, it.b} = 24'hFF80FF;
    send_item(it);
    it = rand_vertex();
    it.x = 24'h800000; it.y = 24'h7FFFFF; it.z = 24'h800000;
    {it.r, it.g, it.b} = 24'hFFFFFF;
    send_item(it);
    // Linear falloff region, then outer below distance with a larger inner.
    it = rand_light(4'd2, 1'b1);
    it.x = 24'd1000; it.y = '0; it.z = '0; it.inner = 25'd200; it.outer = 25'd2000;
    send_item(it);
    it = rand_light(4'd3, 1'b1);
    it.x = '0; it.y = '0; it.z = 24'd900; it.inner = 25'd5000; it.outer = 25'd500;
    send_item(it);
    for (k = 0; k < 4; k++) begin
      it = rand_vertex();
      it.x = 24'(k * 300); it.y = '0; it.z = '0;
      send_item(it);
    end
    // Disable lights and confirm black again.
    for (k = 0; k < 4; k++) begin
      it = rand_light(4'(k), 1'b0);
      send_item(it);
    end
    it = rand_vertex();
    it.x = 24'h7FFFFF; it.y = 24'h800000; it.z = 24'h7FFFFF;
    send_item(it);

    // Random: mostly shading against a shifting light table.
    for (k = 0; k < RandItems; k++) begin
      if (k == RandItems / 3) hold_off = 1'b1;
      if ($urandom_range(0, 3) == 0) it = rand_light(4'($urandom), 1'($urandom_range(0, 3) != 0));
      else it = rand_vertex();
      send_item(it);
    end
    s_tvalid <= 1'b0;

    while (board.pending_colours.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    $display("run: %0d light loads, %0d vertices shaded, %0d results checked",
             loads_sent, shades_sent, board.shaded);
    if (board.mismatches == 0 && board.pending_colours.size() == 0)
      $display("testbench: done, clean");
    else begin
      $display("%0d failures", board.mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/plvs_pkg.sv
design/plvs_ram.sv
design/plvs_datapath.sv
design/plvs_ctrl.sv
design/point_light_vertex_shader_unit.sv
design/plvs_checker.sv
verif/testbench.sv
